### hw/rtl/fall_time_tracker_macros.svh
// ----------------------------------------------------------------------------
// fall_time_tracker_macros.svh - assertion helpers
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FALL_TIME_TRACKER_MACROS_SVH
`define FALL_TIME_TRACKER_MACROS_SVH

// same-cycle implication
`define FTT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FTT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ftt_pkg.sv
// ----------------------------------------------------------------------------
// ftt_pkg - fall time tracker shared definitions
// Widths, register indexes and the control bundle of the min/max scanner.
// ----------------------------------------------------------------------------
package ftt_pkg;

    localparam int WINDOW_DEPTH = 1024;
    localparam int SAMPLE_BITS  = 16;
    localparam int TIME_BITS    = 32;

    localparam int ADDR_BITS = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_BITS = $clog2(WINDOW_DEPTH + 1);

    localparam int EDGE_BITS  = 8;
    localparam int CEIL_BITS  = 16;
    localparam int SCALE_SH   = 8;                  // thresholds scaled by 256
    localparam int COEF_BITS  = EDGE_BITS + 1;      // holds 0..256
    localparam int PROD_BITS  = SAMPLE_BITS + COEF_BITS + 2;
    localparam int THR_BITS   = PROD_BITS + 1;

    localparam int COUNT_BITS    = 32;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_FRACTION = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_CEILING   = 1'd1;

    localparam logic [EDGE_BITS-1:0] EDGE_RESET = 8'd64;
    localparam logic [CEIL_BITS-1:0] CEIL_RESET = 16'd1000;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_GATE   = 1'b1;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [TIME_BITS-1:0]   t_time;

    typedef struct packed {
        logic clear;    // load max with 0, min with the ceiling
        logic acc;      // fold read data into max/min
    } t_scan_ctl;

endpackage

### hw/rtl/ftt_in_if.sv
// ----------------------------------------------------------------------------
// ftt_in_if - input event channel
// Valid/ready channel carrying sensor samples and photogate updates.
// ----------------------------------------------------------------------------
interface ftt_in_if;
    import ftt_pkg::*;

    logic    valid;
    logic    ready;
    logic    command;
    t_sample sample;
    logic    gate_level;
    t_time   timestamp;

    modport source (output valid, command, sample, gate_level, timestamp, input ready);
    modport sink   (input valid, command, sample, gate_level, timestamp, output ready);
endinterface

### hw/rtl/ftt_out_if.sv
// ----------------------------------------------------------------------------
// ftt_out_if - cycle result channel
// Valid/ready channel carrying one result per photogate rising edge.
// ----------------------------------------------------------------------------
interface ftt_out_if;
    import ftt_pkg::*;

    logic                          valid;
    logic                          ready;
    t_sample                       cycle_max;
    t_sample                       cycle_min;
    logic signed [TIME_BITS-1:0]   fall_time;
    logic [COUNT_BITS-1:0]         cycle_count;

    modport source (output valid, cycle_max, cycle_min, fall_time, cycle_count, input ready);
    modport sink   (input valid, cycle_max, cycle_min, fall_time, cycle_count, output ready);
endinterface

### hw/rtl/ftt_ram.sv
// ----------------------------------------------------------------------------
// ftt_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ftt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/ftt_thresh.sv
// ----------------------------------------------------------------------------
// ftt_thresh - threshold multiply and compare unit
// Registers coef * range on load, then tests 256*sample < 256*min + product.
// ----------------------------------------------------------------------------
module ftt_thresh (
    input  logic                            i_clk,
    input  logic                            i_load,
    input  ftt_pkg::t_sample                i_held_max,
    input  ftt_pkg::t_sample                i_held_min,
    input  logic [ftt_pkg::COEF_BITS-1:0]   i_coef,
    input  ftt_pkg::t_sample                i_sample,
    output logic                            o_below
);
    import ftt_pkg::*;

    logic signed [SAMPLE_BITS:0]    range_s;
    logic signed [COEF_BITS:0]      coef_s;
    logic signed [PROD_BITS-1:0]    n_prod;
    logic signed [PROD_BITS-1:0]    r_prod;
    logic signed [THR_BITS-1:0]     base_s;
    logic signed [THR_BITS-1:0]     lim_s;
    logic signed [THR_BITS-1:0]     scaled_s;

    // range may go negative after an empty scan
    assign range_s = $signed({1'b0, i_held_max}) - $signed({1'b0, i_held_min});
    assign coef_s  = $signed({1'b0, i_coef});
    // both operands sign-extended to the product width first
    assign n_prod  = PROD_BITS'(range_s) * PROD_BITS'(coef_s);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= n_prod;
        end
    end

    assign base_s   = $signed(THR_BITS'({i_held_min, {SCALE_SH{1'b0}}}));
    assign scaled_s = $signed(THR_BITS'({i_sample, {SCALE_SH{1'b0}}}));
    assign lim_s    = base_s + THR_BITS'(r_prod);
    assign o_below  = scaled_s < lim_s;
endmodule

### hw/rtl/ftt_minmax.sv
// ----------------------------------------------------------------------------
// ftt_minmax - window max/min accumulator
// Folds one window word per beat of read data into running max and min.
// ----------------------------------------------------------------------------
module ftt_minmax (
    input  logic                        i_clk,
    input  ftt_pkg::t_scan_ctl          i_ctl,
    input  logic [ftt_pkg::CEIL_BITS-1:0] i_ceiling,
    input  ftt_pkg::t_sample            i_data,
    output ftt_pkg::t_sample            o_max,
    output ftt_pkg::t_sample            o_min
);
    import ftt_pkg::*;

    t_sample r_max;
    t_sample r_min;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_max <= '0;
            r_min <= SAMPLE_BITS'(i_ceiling);
        end else if (i_ctl.acc) begin
            if (i_data > r_max) begin
                r_max <= i_data;
            end
            if (i_data < r_min) begin
                r_min <= i_data;
            end
        end
    end

    assign o_max = r_max;
    assign o_min = r_min;
endmodule

### hw/rtl/fall_time_tracker.sv
// ----------------------------------------------------------------------------
// fall_time_tracker - falling edge timing and photogate cycle counter
// Sensor samples fill a ring window and run a threshold test; a photogate
// rising edge scans the window for max/min and emits one result beat.
// ----------------------------------------------------------------------------
// Sample beat: accept, then compare, through the shared threshold unit.
// Gate rising edge: S_SCAN reads one window word per cycle from the RAM, then
//   S_DRAIN, then S_EMIT loads the output register (empty window: no scan).
// Other gate beats: no result. Output register frees the input side.
// Reset (sync, active low): no clearing pass; window entries are read only
//   once written, so fill_count alone tracks them.
// ----------------------------------------------------------------------------
`include "fall_time_tracker_macros.svh"

module fall_time_tracker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ftt_in_if.sink                          i_in_ch,
    ftt_out_if.source                       o_out_ch,
    input  logic                            i_cfg_we,
    input  logic [ftt_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [ftt_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import ftt_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;   // waiting for a beat
    localparam logic [2:0] S_CMP   = 3'd1;   // threshold compare of a sample
    localparam logic [2:0] S_SCAN  = 3'd2;   // issue window reads
    localparam logic [2:0] S_DRAIN = 3'd3;   // last read data lands
    localparam logic [2:0] S_EMIT  = 3'd4;   // load result register

    logic [2:0]            r_state, n_state;

    // config
    logic [EDGE_BITS-1:0]  r_edge;
    logic [CEIL_BITS-1:0]  r_ceil;

    // tracker state
    logic [ADDR_BITS-1:0]  r_wp;
    logic [FILL_BITS-1:0]  r_fill;
    logic                  r_gate_prev;
    logic                  r_in_region;
    t_time                 r_start;
    t_time                 r_end;
    t_sample               r_held_max;
    t_sample               r_held_min;
    logic [COUNT_BITS-1:0] r_cycles;

    // sample being compared
    t_sample               r_sample;
    t_time                 r_stamp;

    // scan
    logic [ADDR_BITS-1:0]  r_idx;
    logic                  r_rd_vld;
    logic                  scan_last;

    // result register
    logic                  r_out_valid;
    t_sample               r_out_max;
    t_sample               r_out_min;
    logic signed [TIME_BITS-1:0] r_out_fall;
    logic [COUNT_BITS-1:0] r_out_count;

    logic                  in_acc;
    logic                  is_sample;
    logic                  is_rise;
    logic                  out_free;
    logic                  below;
    logic [COEF_BITS-1:0]  coef;
    t_scan_ctl             scan_ctl;
    t_sample               rd_data;
    t_sample               acc_max;
    t_sample               acc_min;

    assign i_in_ch.ready = (r_state == S_IDLE);
    assign in_acc        = i_in_ch.valid && i_in_ch.ready;
    assign is_sample     = in_acc && (i_in_ch.command == CMD_SAMPLE);
    assign is_rise       = in_acc && (i_in_ch.command == CMD_GATE)
                           && i_in_ch.gate_level && !r_gate_prev;
    // result slot is free, or its beat goes out this cycle
    assign out_free      = !r_out_valid || o_out_ch.ready;
    assign scan_last     = (r_idx == ADDR_BITS'(r_fill - FILL_BITS'(1)));

    // outside the region test the upper edge, inside the lower one
    assign coef = r_in_region ? COEF_BITS'(r_edge)
                              : COEF_BITS'(1 << SCALE_SH) - COEF_BITS'(r_edge);

    assign scan_ctl.clear = is_rise;
    assign scan_ctl.acc   = r_rd_vld;

    ftt_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (is_sample),
        .i_waddr (r_wp),
        .i_wdata (i_in_ch.sample),
        .i_re    (r_state == S_SCAN),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    ftt_thresh u_thresh (
        .i_clk      (i_clk),
        .i_load     (is_sample),
        .i_held_max (r_held_max),
        .i_held_min (r_held_min),
        .i_coef     (coef),
        .i_sample   (r_sample),
        .o_below    (below)
    );

    ftt_minmax u_minmax (
        .i_clk     (i_clk),
        .i_ctl     (scan_ctl),
        .i_ceiling (r_ceil),
        .i_data    (rd_data),
        .o_max     (acc_max),
        .o_min     (acc_min)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (is_sample) begin
                    n_state = S_CMP;
                end else if (is_rise) begin
                    n_state = (r_fill == '0) ? S_EMIT : S_SCAN;
                end
            end
            S_CMP:   n_state = S_IDLE;
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_edge      <= EDGE_RESET;
            r_ceil      <= CEIL_RESET;
            r_wp        <= '0;
            r_fill      <= '0;
            r_gate_prev <= 1'b0;
            r_in_region <= 1'b0;
            r_start     <= '0;
            r_end       <= '0;
            r_held_max  <= '0;
            r_held_min  <= '0;
            r_cycles    <= '0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_SCAN);

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_EDGE_FRACTION: r_edge <= i_cfg_data[EDGE_BITS-1:0];
                    REG_MIN_CEILING:   r_ceil <= i_cfg_data[CEIL_BITS-1:0];
                endcase
            end

            // window push
            if (is_sample) begin
                r_wp <= (r_wp == ADDR_BITS'(WINDOW_DEPTH - 1)) ? '0
                                                               : r_wp + ADDR_BITS'(1);
                if (r_fill != FILL_BITS'(WINDOW_DEPTH)) begin
                    r_fill <= r_fill + FILL_BITS'(1);
                end
            end

            if (in_acc && (i_in_ch.command == CMD_GATE)) begin
                r_gate_prev <= i_in_ch.gate_level;
            end

            // region entry/exit; product was loaded on accept
            if (r_state == S_CMP && below) begin
                r_in_region <= !r_in_region;
                if (r_in_region) begin
                    r_end <= r_stamp;
                end else begin
                    r_start <= r_stamp;
                end
            end

            if (is_rise) begin
                r_idx <= '0;
            end else if (r_state == S_SCAN) begin
                r_idx <= r_idx + ADDR_BITS'(1);
            end

            if (r_state == S_EMIT && out_free) begin
                r_held_max  <= acc_max;
                r_held_min  <= acc_min;
                r_cycles    <= r_cycles + COUNT_BITS'(1);
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (is_sample) begin
            r_sample <= i_in_ch.sample;
            r_stamp  <= i_in_ch.timestamp;
        end
        if (r_state == S_EMIT && out_free) begin
            r_out_max   <= acc_max;
            r_out_min   <= acc_min;
            r_out_fall  <= $signed(r_end - r_start);
            r_out_count <= r_cycles + COUNT_BITS'(1);
        end
    end

    assign o_out_ch.valid       = r_out_valid;
    assign o_out_ch.cycle_max   = r_out_max;
    assign o_out_ch.cycle_min   = r_out_min;
    assign o_out_ch.fall_time   = r_out_fall;
    assign o_out_ch.cycle_count = r_out_count;

    `FTT_ASSERT_NOW(a_fill_cap, 1'b1, r_fill <= FILL_BITS'(WINDOW_DEPTH), "fill over depth")
    `FTT_ASSERT_NOW(a_wp_fill, r_fill < FILL_BITS'(WINDOW_DEPTH),
                    r_wp == ADDR_BITS'(r_fill), "write pointer off fill")
    `FTT_ASSERT_NEXT(a_rise_busy, is_rise, r_state != S_IDLE, "gate edge not scanned")
    `FTT_ASSERT_NOW(a_count_match, $rose(o_out_ch.valid),
                    o_out_ch.cycle_count == r_cycles, "count mismatch")
endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench - self-checking bench for fall_time_tracker
// Sends sample and photogate beats and predicts every cycle result inside the
// bench. Each result beat is checked field by field. Runs directed cases
// first, then random fall sweeps in four idle/stall phases.
// ----------------------------------------------------------------------------
module testbench;
    import ftt_pkg::*;

    localparam int CYCLE_LIMIT   = 10_000_000;
    localparam int SETTLE_CYCLES = 8;          // lets a trailing sample beat finish its compare
    localparam int PHASE_ITEMS   = 500;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        t_sample                     peak;
        t_sample                     trough;
        logic signed [TIME_BITS-1:0] fall;
        logic [COUNT_BITS-1:0]       count;
    } t_cycle_result;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    ftt_in_if  in_ch ();
    ftt_out_if out_ch ();

    fall_time_tracker u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Predictor state: ring window, fall region tracking, held range
    // ------------------------------------------------------------------------
    t_sample               window_mdl [WINDOW_DEPTH];
    int unsigned           wr_slot;
    int unsigned           filled;
    logic                  gate_seen;
    logic                  falling;
    t_time                 start_ts;
    t_time                 end_ts;
    t_sample               hold_hi;
    t_sample               hold_lo;
    logic [COUNT_BITS-1:0] cycles_seen;
    logic [EDGE_BITS-1:0]  edge_frac;
    logic [CEIL_BITS-1:0]  min_ceil;

    t_cycle_result         pending_results [$];
    int unsigned           miss_count     = 0;
    int unsigned           live_items     = 0;
    int unsigned           send_idle_pct  = 0;
    int unsigned           recv_stall_pct = 0;
    t_time                 stamp_now;

    function void model_reset();
        wr_slot     = 0;
        filled      = 0;
        gate_seen   = 1'b0;
        falling     = 1'b0;
        start_ts    = '0;
        end_ts      = '0;
        hold_hi     = '0;
        hold_lo     = '0;
        cycles_seen = '0;
        edge_frac   = EDGE_RESET;
        min_ceil    = CEIL_RESET;
    endfunction

    function void model_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            REG_EDGE_FRACTION: edge_frac = data[EDGE_BITS-1:0];
            REG_MIN_CEILING:   min_ceil  = data[CEIL_BITS-1:0];
            default: ;
        endcase
    endfunction

    // Advances the predictor by one accepted beat and queues any result.
    // Returns 0 for a gate beat that repeats the current level.
    function automatic bit model_event(logic cmd, t_sample smp, logic lvl, t_time ts);
        longint  base;
        longint  span;
        longint  scaled;
        longint  upper_lim;
        longint  lower_lim;
        t_sample pk;
        t_sample tr;
        bit      changed;

        if (cmd == CMD_SAMPLE) begin
            // thresholds scaled by 256, exact in 64 bits; span may be negative
            base      = longint'(hold_lo);
            span      = longint'(hold_hi) - base;
            scaled    = longint'(smp) * 256;
            upper_lim = base * 256 + (256 - longint'(edge_frac)) * span;
            lower_lim = base * 256 + longint'(edge_frac) * span;

            window_mdl[wr_slot] = smp;
            wr_slot = (wr_slot + 1) % WINDOW_DEPTH;
            if (filled < WINDOW_DEPTH)
                filled++;

            if (!falling && scaled < upper_lim) begin
                falling  = 1'b1;
                start_ts = ts;
            end else if (falling && scaled < lower_lim) begin
                falling  = 1'b0;
                end_ts   = ts;
            end
            return 1'b1;
        end

        changed = (lvl != gate_seen);
        if (lvl && !gate_seen) begin
            pk = '0;
            tr = min_ceil;
            for (int i = 0; i < filled; i++) begin
                if (window_mdl[i] > pk) pk = window_mdl[i];
                if (window_mdl[i] < tr) tr = window_mdl[i];
            end
            hold_hi = pk;
            hold_lo = tr;
            cycles_seen++;
            pending_results.push_back('{peak: pk, trough: tr, fall: end_ts - start_ts,
                                        count: cycles_seen});
        end
        gate_seen = lvl;
        return changed;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random stall, compare each beat with the oldest prediction
    // ------------------------------------------------------------------------
    initial begin
        t_cycle_result want;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (pending_results.size() == 0) begin
                    miss_count++;
                    if (miss_count <= REPORT_LIMIT)
                        $display("unexpected result beat: max %0d min %0d fall %0d count %0d",
                                 out_ch.cycle_max, out_ch.cycle_min, out_ch.fall_time,
                                 out_ch.cycle_count);
                end else begin
                    want = pending_results.pop_front();
                    if (out_ch.cycle_max !== want.peak || out_ch.cycle_min !== want.trough ||
                        out_ch.fall_time !== want.fall || out_ch.cycle_count !== want.count)
                    begin
                        miss_count++;
                        if (miss_count <= REPORT_LIMIT) begin
                            $write("result mismatch: expected max %0d min %0d fall %0d count %0d, ",
                                   want.peak, want.trough, want.fall, want.count);
                            $display("got max %0d min %0d fall %0d count %0d",
                                     out_ch.cycle_max, out_ch.cycle_min, out_ch.fall_time,
                                     out_ch.cycle_count);
                        end
                    end
                end
            end
            out_ch.ready <= i_rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    function automatic t_time advance_stamp();
        // mostly a running clock that wraps, now and then a jump anywhere
        if ($urandom_range(0, 19) == 0)
            stamp_now = $urandom();
        else
            stamp_now = stamp_now + $urandom_range(1, 4000);
        return stamp_now;
    endfunction

    task automatic send_event(logic cmd, t_sample smp, logic lvl, t_time ts);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.command    <= cmd;
        in_ch.sample     <= smp;
        in_ch.gate_level <= lvl;
        in_ch.timestamp  <= ts;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (model_event(cmd, smp, lvl, ts))
            live_items++;
    endtask

    // unused fields carry random bits
    task automatic send_sample(t_sample smp);
        send_event(CMD_SAMPLE, smp, 1'($urandom_range(0, 1)), advance_stamp());
    endtask

    task automatic send_gate(logic lvl);
        send_event(CMD_GATE, t_sample'($urandom_range(0, 65535)), lvl, advance_stamp());
    endtask

    // drop valid, let every predicted beat arrive, then let a trailing
    // sample beat finish its compare
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        model_write(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(logic [CFG_DATA_BITS-1:0] edge_word,
                             logic [CFG_DATA_BITS-1:0] ceil_word);
        wait_idle();
        write_reg(REG_EDGE_FRACTION, edge_word);
        write_reg(REG_MIN_CEILING, ceil_word);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // rising edge on an empty window, then repeated and falling levels
    task automatic test_empty_window();
        send_event(CMD_GATE, 16'hFFFF, 1'b1, 32'h0000_0000);
        send_gate(1'b1);
        send_gate(1'b0);
        send_gate(1'b0);
    endtask

    // full-scale samples and stamps while the held range is still inverted
    task automatic test_sample_extremes();
        send_event(CMD_SAMPLE, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
        send_event(CMD_SAMPLE, 16'h0000, 1'b0, 32'h0000_0000);
        send_gate(1'b1);
    endtask

    // held range 0..65535 at edge 64: upper 49151.25, lower 16383.75;
    // samples sit right on both sides, stamps wrap between start and end
    task automatic test_fall_crossing();
        send_sample(16'd1000);
        send_event(CMD_SAMPLE, 16'd60000, 1'b0, 32'hFFFF_FFE0);
        send_event(CMD_SAMPLE, 16'd49151, 1'b1, 32'hFFFF_FFF0);
        send_event(CMD_SAMPLE, 16'd16384, 1'b0, 32'hFFFF_FFF8);
        send_event(CMD_SAMPLE, 16'd16383, 1'b1, 32'h0000_0010);
        send_gate(1'b0);
        send_gate(1'b1);
    endtask

    // edge at 0, past half and at half; ceiling at both ends
    task automatic test_edge_config();
        configure(16'd0, 16'd0);
        send_sample(16'd30000);
        send_sample(16'd0);
        send_gate(1'b0);
        send_gate(1'b1);

        configure(16'hA5FF, 16'hFFFF);      // upper data bits are dropped
        send_sample(16'd100);
        send_sample(16'd65535);
        send_gate(1'b0);
        send_gate(1'b1);

        configure(16'd128, 16'd500);
        send_sample(16'd40000);
        send_gate(1'b0);
        send_gate(1'b1);
    endtask

    // Mostly falling sweeps with jitter closed by a gate pulse, the rest
    // single noise beats. Halfway through, the sender holds off until every
    // result is in.
    task automatic test_random_phase(int unsigned idle_pct, int unsigned stall_pct,
                                     logic [CFG_DATA_BITS-1:0] edge_word,
                                     logic [CFG_DATA_BITS-1:0] ceil_word);
        int unsigned goal;
        int          top;
        int          bottom;
        int          steps;
        int          level;
        bit          paused;

        configure(edge_word, ceil_word);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        goal   = live_items + PHASE_ITEMS;
        paused = 1'b0;
        while (live_items < goal) begin
            if (!paused && live_items + PHASE_ITEMS / 2 >= goal) begin
                wait_idle();
                paused = 1'b1;
            end
            if ($urandom_range(0, 3) != 0) begin
                top    = $urandom_range(30000, 65535);
                bottom = $urandom_range(0, 25000);
                if ($urandom_range(0, 7) == 0) top = 65535;
                if ($urandom_range(0, 7) == 0) bottom = 0;
                steps = $urandom_range(2, 12);
                for (int k = 0; k <= steps; k++) begin
                    level = top - ((top - bottom) * k) / steps
                            + int'($urandom_range(0, 600)) - 300;
                    if (level < 0) level = 0;
                    if (level > 65535) level = 65535;
                    send_sample(t_sample'(level));
                end
                send_gate(1'b0);
                send_gate(1'b1);
            end else if ($urandom_range(0, 1) == 0) begin
                send_sample(t_sample'($urandom_range(0, 65535)));
            end else begin
                send_gate(1'($urandom_range(0, 1)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= REG_EDGE_FRACTION;
        i_cfg_data       <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.command    <= CMD_SAMPLE;
        in_ch.sample     <= '0;
        in_ch.gate_level <= 1'b0;
        in_ch.timestamp  <= '0;
        model_reset();
        stamp_now = $urandom();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_window();
        test_sample_extremes();
        test_fall_crossing();
        test_edge_config();

        test_random_phase(0, 0, 16'd64, 16'd1000);
        test_random_phase(58, 0, 16'd0, 16'hFFFF);
        test_random_phase(0, 58, 16'd128, 16'd0);
        test_random_phase(35, 35, CFG_DATA_BITS'($urandom_range(0, 65535)),
                          CFG_DATA_BITS'($urandom_range(0, 65535)));

        // a full-window scan is the longest the block may still be busy
        wait_idle();
        repeat (WINDOW_DEPTH + 16) @(posedge i_clk);
        if (miss_count == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
